>>> hdl/gss_pkg.sv
// Shared types and constants of the gate step sequencer.
package gss_pkg;

    // One grid cell as held in the cell memory.
    typedef struct packed {
        logic       en;
        logic [6:0] note;
        logic [6:0] vel;
    } t_cell;

    localparam t_cell CELL_RESET = '{en: 1'b0, note: 7'd36, vel: 7'd64};

    // Input item kinds, carried on the slave-side tuser.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Register value of step_count after reset.
    localparam int STEP_COUNT_RESET = 32;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_ON    = 5'b01000,
        S_OFF   = 5'b10000
    } t_state;

endpackage

>>> hdl/gate_step_sequencer.sv
// Step sequencer top level: command decode, tick sequencing and event output.
//
// Slave channel (i_s_*) takes commands: tuser selects tick, write one cell or
// clear the cells of the columns in use; tdata carries the cell fields.
// Master channel (o_m_*) delivers gate events, tuser high for gate-on, tlast
// on the final event of a tick. Writes and clears give no events.
// A tick is accepted in S_IDLE, reads its first row from the cell memory in
// S_RD, then passes S_ON and S_OFF for each row whether or not the row has a
// gate-on. Both reads of a row (current and previous column) come from the two
// read ports in the same cycle. A write lands in the cycle it is accepted; a
// clear writes one cell a cycle through the single write port.
// After reset the block sweeps the whole memory to the default cell
// with o_s_tready low; i_cfg_we is taken at any time.
// step_count resets to 32 (clamped to COLUMNS), the step to 0.
// Events wait in an output register; while the receiver stalls, the tick
// holds at the next event and the slave side stays not ready.
module gate_step_sequencer import gss_pkg::*; #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,   // step_count
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,     // column[4:0] row[7:5] enabled[8] note[15:9] velocity[22:16]
    input  logic [1:0]  i_s_tuser,     // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,     // event_row[2:0] event_note[9:3] event_velocity[16:10] event_step[21:17]
    output logic        o_m_tuser,     // is_gate_on[0]
    output logic        o_m_tlast      // last
);

    localparam int DEPTH   = COLUMNS * ROWS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int LEN_W   = $clog2(COLUMNS + 1);
    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LEN_RST = (COLUMNS < STEP_COUNT_RESET) ? COLUMNS : STEP_COUNT_RESET;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len;
    logic [SW-1:0]     r_step, n_step;
    logic [SW-1:0]     r_prv, n_prv;
    logic [RW-1:0]     r_row, n_row;
    logic [AW-1:0]     r_cur_addr, n_cur_addr;
    logic [AW-1:0]     r_prv_addr, n_prv_addr;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [AW-1:0]     r_clr_last, n_clr_last;

    logic              r_out_valid;
    logic              r_out_on;
    logic              r_out_last;
    logic [2:0]        r_out_row;
    logic [6:0]        r_out_note;
    logic [6:0]        r_out_vel;
    logic [4:0]        r_out_step;

    logic [4:0]        in_col;
    logic [2:0]        in_row;
    t_cell             in_cell;
    logic              s_fire;
    logic              in_grid;
    logic [AW-1:0]     in_addr;

    logic [6:0]        cfg_ext;
    logic [LEN_W-1:0]  cfg_len;

    logic [LEN_W-1:0]  step_inc;
    logic [SW-1:0]     tick_next;
    logic [SW-1:0]     tick_prv;

    logic [AW-1:0]     base_cur;
    logic [AW-1:0]     base_prv;
    logic              row_last;
    logic              slot_free;
    logic              on_fire;
    logic              off_fire;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    t_cell             wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    t_cell             rd_cur;
    t_cell             rd_prv;

    // Input unpacking and write decode
    assign in_col  = i_s_tdata[4:0];
    assign in_row  = i_s_tdata[7:5];
    assign in_cell = '{en: i_s_tdata[8], note: i_s_tdata[15:9], vel: i_s_tdata[22:16]};
    assign s_fire  = i_s_tvalid && o_s_tready;
    assign in_grid = (int'(in_col) < COLUMNS) && (int'(in_row) < ROWS);
    assign in_addr = AW'(int'(in_col) * ROWS + int'(in_row));

    // Active length, clamped once when written
    assign cfg_ext = {1'b0, i_cfg_wdata};
    always_comb begin
        if (cfg_ext == 7'd0) begin
            cfg_len = LEN_W'(1);
        end else if (int'(cfg_ext) > COLUMNS) begin
            cfg_len = LEN_W'(COLUMNS);
        end else begin
            cfg_len = LEN_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(LEN_RST);
        end else if (i_cfg_we) begin
            r_len <= cfg_len;
        end
    end

    // Step advance; wrap once step+1 reaches the length
    assign step_inc  = LEN_W'(r_step) + LEN_W'(1);
    assign tick_next = (step_inc >= r_len) ? SW'(0) : SW'(step_inc);
    assign tick_prv  = (tick_next != SW'(0)) ? tick_next - SW'(1) : SW'(r_len - LEN_W'(1));

    assign base_cur  = AW'(int'(r_step) * ROWS);
    assign base_prv  = AW'(int'(r_prv) * ROWS);
    assign row_last  = (r_row == RW'(ROWS - 1));
    assign slot_free = !r_out_valid || i_m_tready;
    assign on_fire   = (r_state == S_ON) && rd_cur.en && slot_free;
    assign off_fire  = (r_state == S_OFF) && slot_free;

    assign o_s_tready = (r_state == S_IDLE);

    // Control sequencing
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_prv      = r_prv;
        n_row      = r_row;
        n_cur_addr = r_cur_addr;
        n_prv_addr = r_prv_addr;
        n_clr_addr = r_clr_addr;
        n_clr_last = r_clr_last;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == r_clr_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    case (i_s_tuser)
                        CMD_TICK: begin
                            n_step  = tick_next;
                            n_prv   = tick_prv;
                            n_row   = RW'(0);
                            n_state = S_RD;
                        end
                        CMD_CLEAR: begin
                            n_clr_addr = AW'(0);
                            n_clr_last = AW'(int'(r_len) * ROWS - 1);
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_cur_addr = base_cur;
                n_prv_addr = base_prv;
                n_state    = S_ON;
            end
            S_ON: begin
                // a disabled cell skips straight to its gate-off
                if (on_fire || !rd_cur.en) begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                if (off_fire) begin
                    if (row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row      = r_row + RW'(1);
                        n_cur_addr = r_cur_addr + AW'(1);
                        n_prv_addr = r_prv_addr + AW'(1);
                        n_state    = S_ON;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_step     <= SW'(0);
            r_prv      <= SW'(0);
            r_row      <= RW'(0);
            r_cur_addr <= AW'(0);
            r_prv_addr <= AW'(0);
            r_clr_addr <= AW'(0);
            r_clr_last <= AW'(DEPTH - 1);
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_prv      <= n_prv;
            r_row      <= n_row;
            r_cur_addr <= n_cur_addr;
            r_prv_addr <= n_prv_addr;
            r_clr_addr <= n_clr_addr;
            r_clr_last <= n_clr_last;
        end
    end

    // Memory port control: fetch the next row while the gate-off leaves
    assign wr_en     = (r_state == S_CLEAR) ||
                       (s_fire && (i_s_tuser == CMD_WRITE) && in_grid);
    assign wr_addr   = (r_state == S_CLEAR) ? r_clr_addr : in_addr;
    assign wr_data   = (r_state == S_CLEAR) ? CELL_RESET : in_cell;
    assign rd_en     = (r_state == S_RD) || (off_fire && !row_last);
    assign rd_addr_a = (r_state == S_RD) ? base_cur : r_cur_addr + AW'(1);
    assign rd_addr_b = (r_state == S_RD) ? base_prv : r_prv_addr + AW'(1);

    gss_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_cur),
        .o_rd_data_b (rd_prv)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (on_fire || off_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (on_fire) begin
            r_out_on   <= 1'b1;
            r_out_last <= 1'b0;
            r_out_row  <= 3'(r_row);
            r_out_note <= rd_cur.note;
            r_out_vel  <= rd_cur.vel;
            r_out_step <= 5'(r_step);
        end else if (off_fire) begin
            r_out_on   <= 1'b0;
            r_out_last <= row_last;
            r_out_row  <= 3'(r_row);
            r_out_note <= rd_prv.note;
            r_out_vel  <= 7'd0;
            r_out_step <= 5'(r_step);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_step, r_out_vel, r_out_note, r_out_row};
    assign o_m_tuser  = r_out_on;
    assign o_m_tlast  = r_out_last;

    // No cell write may land while a tick is reading the memory
    a_no_write_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_ON || r_state == S_OFF) |-> !wr_en)
        else $error("cell write during tick read phase");

    // The step being played and the one before it lie inside the active length
    a_step_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (LEN_W'(r_step) < r_len && LEN_W'(r_prv) < r_len))
        else $error("step outside active length");

    // A tick ends exactly after the gate-off of the last row
    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (off_fire && row_last) |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("tick did not end on last event");

    // Clearing sweep stays within its end address
    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_clr_addr <= r_clr_last))
        else $error("clear sweep overran");

    // Row counter never passes the last row
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < ROWS)
        else $error("row counter out of range");

endmodule

>>> hdl/gss_cell_ram.sv
// Cell memory: one write port, two registered read ports.
module gss_cell_ram import gss_pkg::*; #(
    parameter int DEPTH = 192,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_cell         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output t_cell         o_rd_data_a,
    output t_cell         o_rd_data_b
);

    t_cell r_mem [DEPTH];
    t_cell r_rd_a;
    t_cell r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> verif/tb_gate_step_sequencer.sv
// Self-checking testbench of the gate step sequencer: directed and random command streams.
module tb_gate_step_sequencer;
    import gss_pkg::*;

    localparam int NCOLS  = 32;
    localparam int NROWS  = 6;
    // Long enough to cover a clear of every column plus a full tick.
    localparam int SETTLE = 240;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam t_cell BLANK_CELL = '{en: 1'b0, note: 7'd36, vel: 7'd64};

    typedef struct packed {
        logic       gate_on;
        logic [2:0] row;
        logic [6:0] note;
        logic [6:0] vel;
        logic [4:0] step;
        logic       is_last;
    } t_gate_event;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [5:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata   = '0;    // column[4:0] row[7:5] enabled[8] note[15:9] velocity[22:16]
    logic [1:0]  i_s_tuser   = '0;    // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;           // event_row[2:0] event_note[9:3] event_velocity[16:10] event_step[21:17]
    logic        o_m_tuser;           // is_gate_on[0]
    logic        o_m_tlast;           // last

    // Predictor state
    t_cell         grid [NCOLS*NROWS];
    logic [4:0]    play_step;
    logic [5:0]    step_count_reg;
    t_gate_event   due_events [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    gate_step_sequencer #(
        .COLUMNS (NCOLS),
        .ROWS    (NROWS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    initial forever #10 i_clk = ~i_clk;

    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void reset_grid();
        for (int i = 0; i < NCOLS*NROWS; i++) grid[i] = BLANK_CELL;
        play_step      = '0;
        step_count_reg = 6'd32;
    endfunction

    function automatic int unsigned played_length();
        if (step_count_reg == 0) return 1;
        if (step_count_reg > NCOLS) return NCOLS;
        return step_count_reg;
    endfunction

    // Apply one command to the grid and queue the gate events a tick produces.
    function automatic void sequence_command(input logic [1:0] cmd, input logic [4:0] col,
                                             input logic [2:0] row, input logic en,
                                             input logic [6:0] note, input logic [6:0] vel);
        int unsigned len;
        int unsigned nxt;
        int unsigned prv;
        t_cell       cur_cell;
        t_cell       prv_cell;
        len = played_length();
        case (cmd)
            CMD_TICK: begin
                nxt = play_step + 1;
                if (nxt >= len) nxt = 0;
                play_step = 5'(nxt);
                prv = (nxt > 0) ? nxt - 1 : len - 1;
                for (int y = 0; y < NROWS; y++) begin
                    cur_cell = grid[nxt*NROWS + y];
                    prv_cell = grid[prv*NROWS + y];
                    if (cur_cell.en)
                        due_events.push_back('{1'b1, 3'(y), cur_cell.note, cur_cell.vel,
                                               5'(nxt), 1'b0});
                    // The gate-off closes each row, so the final row's one ends the tick.
                    due_events.push_back('{1'b0, 3'(y), prv_cell.note, 7'd0, 5'(nxt),
                                           y == NROWS - 1});
                end
            end
            CMD_WRITE: begin
                if (row < NROWS && col < NCOLS) grid[col*NROWS + row] = '{en, note, vel};
            end
            CMD_CLEAR: begin
                for (int x = 0; x < len; x++)
                    for (int y = 0; y < NROWS; y++) grid[x*NROWS + y] = BLANK_CELL;
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Receiver: random stalls, or a long hold-off counted here when one is requested.
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_events
        t_gate_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_events.size() == 0) begin
                flag_mismatch($sformatf("gate event with none due, tdata %h", o_m_tdata));
            end else begin
                want = due_events.pop_front();
                if (o_m_tuser !== want.gate_on)
                    flag_mismatch($sformatf("gate_on got %b expected %b",
                                            o_m_tuser, want.gate_on));
                if (o_m_tdata[2:0] !== want.row)
                    flag_mismatch($sformatf("row got %0d expected %0d",
                                            o_m_tdata[2:0], want.row));
                if (o_m_tdata[9:3] !== want.note)
                    flag_mismatch($sformatf("note got %0d expected %0d",
                                            o_m_tdata[9:3], want.note));
                if (o_m_tdata[16:10] !== want.vel)
                    flag_mismatch($sformatf("velocity got %0d expected %0d",
                                            o_m_tdata[16:10], want.vel));
                if (o_m_tdata[21:17] !== want.step)
                    flag_mismatch($sformatf("step got %0d expected %0d",
                                            o_m_tdata[21:17], want.step));
                if (o_m_tdata[23:22] !== 2'b00)
                    flag_mismatch($sformatf("padding got %b", o_m_tdata[23:22]));
                if (o_m_tlast !== want.is_last)
                    flag_mismatch($sformatf("last got %b expected %b",
                                            o_m_tlast, want.is_last));
            end
        end
    end

    // Offer one command and hold it until the transfer completes.
    task automatic send_cmd(input logic [1:0] cmd, input logic [4:0] col, input logic [2:0] row,
                            input logic en, input logic [6:0] note, input logic [6:0] vel);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, vel, note, en, row, col};
        do @(posedge i_clk); while (!o_s_tready);
        sequence_command(cmd, col, row, en, note, vel);
    endtask

    task automatic send_tick();
        send_cmd(CMD_TICK, 5'($urandom), 3'($urandom), 1'($urandom), 7'($urandom),
                 7'($urandom));
    endtask

    task automatic drain_events();
        i_s_tvalid <= 1'b0;
        while (due_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_step_count(input logic [5:0] value);
        drain_events();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        step_count_reg = value;
    endtask

    // Mostly ticks and writes into the played columns, with some clears and noise.
    task automatic send_random_command();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [4:0]  col;
        logic [2:0]  row;
        pick = $urandom_range(99);
        col  = ($urandom_range(7) == 0) ? 5'($urandom_range(NCOLS - 1))
                                         : 5'($urandom_range(played_length() - 1));
        row  = ($urandom_range(15) == 0) ? 3'($urandom_range(7, NROWS))
                                         : 3'($urandom_range(NROWS - 1));
        if (pick < 45)      cmd = CMD_TICK;
        else if (pick < 92) cmd = CMD_WRITE;
        else if (pick < 96) cmd = CMD_CLEAR;
        else                cmd = CMD_SPARE;
        send_cmd(cmd, col, row, 1'($urandom), 7'($urandom), 7'($urandom));
    endtask

    task automatic test_power_on();
        repeat (2) send_tick();
    endtask

    task automatic test_cell_writes();
        send_cmd(CMD_WRITE, 5'd0, 3'd0, 1'b1, 7'd127, 7'd127);
        send_cmd(CMD_WRITE, 5'd31, 3'd5, 1'b1, 7'd0, 7'd0);
        send_cmd(CMD_WRITE, 5'd3, 3'd2, 1'b1, 7'h55, 7'h2A);
        // Rows outside the grid: drop
        send_cmd(CMD_WRITE, 5'd3, 3'd6, 1'b1, 7'd1, 7'd1);
        send_cmd(CMD_WRITE, 5'd3, 3'd7, 1'b1, 7'd2, 7'd2);
        send_cmd(CMD_SPARE, 5'd3, 3'd2, 1'b0, 7'd9, 7'd9);
        send_tick();
    endtask

    task automatic test_length_limits();
        // Zero length plays as a single column
        set_step_count(6'd0);
        repeat (2) send_tick();
        set_step_count(6'd2);
        send_cmd(CMD_WRITE, 5'd20, 3'd1, 1'b1, 7'd100, 7'd5);
        repeat (2) send_tick();
        set_step_count(6'd32);
        repeat (3) send_tick();
        // Shrink below the current step: wrap to column zero
        set_step_count(6'd3);
        send_tick();
        set_step_count(6'd63);
        send_tick();
    endtask

    task automatic test_clear();
        set_step_count(6'd4);
        send_cmd(CMD_WRITE, 5'd2, 3'd1, 1'b1, 7'd60, 7'd70);
        send_cmd(CMD_WRITE, 5'd10, 3'd4, 1'b1, 7'd61, 7'd71);
        send_cmd(CMD_CLEAR, 5'd0, 3'd0, 1'b0, 7'd0, 7'd0);
        repeat (3) send_tick();
    endtask

    task automatic test_random_traffic();
        logic [5:0] lengths [6];
        lengths = '{6'd1, 6'd32, 6'd63, 6'd5, 6'($urandom_range(63, 1)),
                    6'($urandom_range(12, 1))};
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 14; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            set_step_count(lengths[seg]);
            repeat (46) send_random_command();
        end
    endtask

    task automatic test_backpressure();
        set_step_count(6'($urandom_range(32, 8)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 400;
        repeat (20) send_tick();
        // Pause until every event has arrived, then go on
        drain_events();
        repeat (10) send_random_command();
    endtask

    initial begin
        reset_grid();
        send_idle_pct = 14;
        recv_idle_pct = 62;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_on();
        test_cell_writes();
        test_length_limits();
        test_clear();
        test_random_traffic();
        test_backpressure();
        drain_events();
        if (mismatch_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
hdl/gss_pkg.sv
hdl/gss_cell_ram.sv
hdl/gate_step_sequencer.sv
verif/tb_gate_step_sequencer.sv
